// ===== rtl/kact_pkg.sv =====
// shared types and constants for the keepalive client timeout table
// no dependencies; imported by kact_slot_ram, the top level and the bench files
package kact_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 16;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned CFG_W   = 22;
  localparam int unsigned WAIT_W  = 15;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(30000);
  localparam logic [WAIT_W-1:0] WAIT_MIN = WAIT_W'(1000);

  localparam logic [CFG_W-1:0] CHECK_PERIOD_RST = CFG_W'(5000);
  localparam logic [CFG_W-1:0] DEAD_AFTER_RST   = CFG_W'(10000);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REFRESH = 2'd2,
    OP_SWEEP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_PROBE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_CHECK_PERIOD = 2'd0,
    REG_DEAD_AFTER   = 2'd1,
    REG_PROBE_ENABLE = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one slot entry as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] seen;
  } slot_word_t;

endpackage

// ===== rtl/kact_slot_ram.sv =====
// slot memory: client id and last-seen time per slot
// one write port, one read port with registered read data; uses kact_pkg
module kact_slot_ram
  import kact_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_SLOTS_DEF,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  slot_word_t        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output slot_word_t        rd_data_o
);

  slot_word_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/keepalive_client_timeout_table_core.sv =====
// keepalive client timeout table, top level: sequencer, slot scan pipeline,
// configuration registers and result register; uses kact_pkg and kact_slot_ram
//
// the done result of an item is loaded from ST_DONE, once the last slot has
// passed stages b and c; stalls on the result side hold the scan
// a new request is taken only in ST_IDLE; while the result side does not stall,
// the scan reads one slot per cycle through the single slot memory read port
// reset: all slots free, registers at 5000 / 10000 / 1; slot memory itself
// is not cleared, since an entry's contents are only used once its used bit is set
module keepalive_client_timeout_table_core
  import kact_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [ID_W-1:0]     client_id_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [ID_W-1:0]     slot_client_o,
  output logic                ok_o,
  output logic [WAIT_W-1:0]   next_wait_ms_o,
  output logic                last_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int unsigned IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned DIFF_W = TIME_W + 1;   // signed now - seen
  localparam int unsigned LEFT_W = TIME_W + 2;   // signed period - diff

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] check_period_q;
  logic [CFG_W-1:0] dead_after_q;
  logic             probe_en_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  // byte offset low bits are ignored, register index is the word address
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_period_q <= CHECK_PERIOD_RST;
      dead_after_q   <= DEAD_AFTER_RST;
      probe_en_q     <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CHECK_PERIOD: check_period_q <= pwdata[CFG_W-1:0];
        REG_DEAD_AFTER:   dead_after_q   <= pwdata[CFG_W-1:0];
        REG_PROBE_ENABLE: probe_en_q     <= pwdata[0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CHECK_PERIOD: prdata = PDATA_W'(check_period_q);
      REG_DEAD_AFTER:   prdata = PDATA_W'(dead_after_q);
      REG_PROBE_ENABLE: prdata = PDATA_W'(probe_en_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // state and request registers
  // ---------------------------------------------------------------------
  state_e state_q, state_d;

  op_e               op_q;
  logic [ID_W-1:0]   cid_q;
  logic [TIME_W-1:0] now_q;
  logic              found_q;     // add claimed a slot / remove-refresh hit
  logic [WAIT_W-1:0] best_q;      // running minimum of time left

  logic [MAX_SLOTS-1:0] used_q;   // per-slot used bits
  logic [CNT_W-1:0]     cnt_q;    // next slot to read

  // scan pipeline: stage b sees slot memory data, stage c decides
  logic              b_vld_q;
  logic [IDX_W-1:0]  b_idx_q;
  logic              c_vld_q;
  logic [IDX_W-1:0]  c_idx_q;
  logic              c_cnt_q;     // slot counts toward the next wait
  logic [ID_W-1:0]   c_id_q;
  logic [DIFF_W-1:0] c_diff_q;

  // result register
  logic              out_valid_q;
  kind_e             kind_q;
  logic [ID_W-1:0]   client_q;
  logic              ok_q;
  logic [WAIT_W-1:0] wait_q;
  logic              last_q;

  // control from the sequencer
  logic stall;       // result register full and not taken
  logic issue;       // slots still to read
  logic start;
  logic rd_en;
  logic done_load;

  assign stall = out_valid_q & ~out_ready_i;
  assign issue = (cnt_q < CNT_W'(MAX_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_ready_o = 1'b0;
    start     = 1'b0;
    rd_en     = 1'b0;
    done_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          start   = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          rd_en = issue;
          // the last slot leaves stage c in this cycle
          if (!issue && !b_vld_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!stall) begin
          done_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // slot memory
  // ---------------------------------------------------------------------
  slot_word_t       rd_word;
  slot_word_t       wr_word;
  logic             wr_en;

  kact_slot_ram #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (b_idx_q),
    .wr_data_i (wr_word),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[IDX_W-1:0]),
    .rd_data_o (rd_word)
  );

  // ---------------------------------------------------------------------
  // stage b: apply the request to one slot, form now - seen
  // ---------------------------------------------------------------------
  logic              b_fire;
  logic              b_used;
  logic              b_claim;     // add takes this free slot
  logic              b_hit;       // first used slot with matching id
  logic              b_restamp;
  logic              b_counted;
  logic [TIME_W-1:0] b_seen;
  logic [DIFF_W-1:0] b_diff;

  assign b_fire = b_vld_q & ~stall;

  always_comb begin
    b_used    = used_q[b_idx_q];
    b_claim   = (op_q == OP_ADD) && !b_used && !found_q;
    b_hit     = (op_q inside {OP_REMOVE, OP_REFRESH}) && b_used &&
                (rd_word.id == cid_q) && !found_q;
    b_restamp = b_claim || (b_hit && (op_q == OP_REFRESH));
    b_seen    = b_restamp ? now_q : rd_word.seen;
    // a removed slot no longer counts toward the wait
    b_counted = b_claim || (b_used && !(b_hit && (op_q == OP_REMOVE)));
    b_diff    = {1'b0, now_q} - {1'b0, b_seen};
    wr_en     = b_fire && b_restamp;
    wr_word.id   = b_claim ? cid_q : rd_word.id;
    wr_word.seen = now_q;
  end

  // ---------------------------------------------------------------------
  // stage c: expire / probe decision and time left to the next check
  // ---------------------------------------------------------------------
  logic              c_fire;
  logic              c_over;      // silent longer than the dead limit
  logic              c_expire;
  logic              c_probe;
  logic [LEFT_W-1:0] c_left;
  logic [WAIT_W-1:0] c_left_clamp;

  assign c_fire = c_vld_q & ~stall;

  always_comb begin
    // silence is taken modulo the time width, so a future stamp looks old
    c_over   = c_diff_q[TIME_W-1:0] > TIME_W'(dead_after_q);
    c_expire = (op_q == OP_SWEEP) && c_cnt_q && c_over;
    c_probe  = (op_q == OP_SWEEP) && c_cnt_q && !c_over && probe_en_q;
    c_left   = LEFT_W'(check_period_q) - {c_diff_q[DIFF_W-1], c_diff_q};
    // overdue slots count as zero time left
    if (c_left[LEFT_W-1]) begin
      c_left_clamp = '0;
    end else if (c_left > LEFT_W'(WAIT_MAX)) begin
      c_left_clamp = WAIT_MAX;
    end else begin
      c_left_clamp = c_left[WAIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (start) begin
      cnt_q   <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (state_q == ST_SCAN && !stall) begin
      cnt_q   <= issue ? cnt_q + CNT_W'(1) : cnt_q;
      b_vld_q <= issue;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q    <= op_e'(operation_i);
      cid_q   <= client_id_i;
      now_q   <= now_ms_i;
      found_q <= 1'b0;
      best_q  <= WAIT_MAX;
    end else begin
      if (state_q == ST_SCAN && !stall) begin
        b_idx_q  <= cnt_q[IDX_W-1:0];
        c_idx_q  <= b_idx_q;
        c_cnt_q  <= b_counted;
        c_id_q   <= rd_word.id;
        c_diff_q <= b_diff;
      end
      if (b_fire && (b_claim || b_hit)) begin
        found_q <= 1'b1;
      end
      if (c_fire && c_cnt_q && !c_expire && (c_left_clamp < best_q)) begin
        best_q <= c_left_clamp;
      end
    end
  end

  // used bits: stage b claims or frees, stage c frees expired slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (b_fire && b_claim) begin
        used_q[b_idx_q] <= 1'b1;
      end
      if (b_fire && b_hit && (op_q == OP_REMOVE)) begin
        used_q[b_idx_q] <= 1'b0;
      end
      if (c_fire && c_expire) begin
        used_q[c_idx_q] <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_load || (c_fire && (c_expire || c_probe))) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_load) begin
      kind_q   <= KIND_DONE;
      client_q <= '0;
      ok_q     <= (op_q == OP_SWEEP) ? 1'b1 : found_q;
      wait_q   <= (best_q < WAIT_MIN) ? WAIT_MIN : best_q;
      last_q   <= 1'b1;
    end else if (c_fire && (c_expire || c_probe)) begin
      kind_q   <= c_expire ? KIND_EXPIRED : KIND_PROBE;
      client_q <= c_id_q;
      ok_q     <= 1'b0;
      wait_q   <= '0;
      last_q   <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign slot_client_o  = client_q;
  assign ok_o           = ok_q;
  assign next_wait_ms_o = wait_q;
  assign last_o         = last_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == KIND_DONE)
    else $error("last flag on a non-done result");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_SCAN && cnt_q == '0 && !b_vld_q)
    else $error("scan did not restart from the first slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && stall |=> $stable(cnt_q) && $stable(used_q))
    else $error("scan advanced while the result side stalled");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SLOTS))
    else $error("slot counter ran past the table");

  a_wait_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |->
      next_wait_ms_o >= WAIT_MIN && next_wait_ms_o <= WAIT_MAX)
    else $error("next wait outside its clamp range");

endmodule

// ===== bench/kact_table_checker.sv =====
// result checker for the keepalive client timeout table: watches the request,
// result and configuration ports, predicts every result and compares; uses kact_pkg
module kact_table_checker
  import kact_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         operation_i,
  input  logic [ID_W-1:0]    client_id_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [ID_W-1:0]    slot_client_i,
  input  logic               ok_i,
  input  logic [WAIT_W-1:0]  next_wait_ms_i,
  input  logic               last_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic               pready_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   client;
    logic              ok;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } table_result_t;

  logic              slot_used [MAX_SLOTS];
  logic [ID_W-1:0]   slot_id   [MAX_SLOTS];
  logic [TIME_W-1:0] slot_seen [MAX_SLOTS];
  logic [CFG_W-1:0]  check_period;
  logic [CFG_W-1:0]  dead_after;
  logic              probe_on;

  table_result_t queued_results [$];
  int            mismatches;

  // smallest time left to a check over used slots, clamped to the wait range
  function automatic logic [WAIT_W-1:0] wait_until_check(logic [TIME_W-1:0] now);
    logic [63:0] best;
    logic [63:0] due;
    logic [63:0] left;
    best = 64'(WAIT_MAX);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (slot_used[i]) begin
        due  = 64'(slot_seen[i]) + 64'(check_period);
        left = (due > 64'(now)) ? due - 64'(now) : 64'd0;
        if (left < best) best = left;
      end
    end
    if (best < 64'(WAIT_MIN)) best = 64'(WAIT_MIN);
    return best[WAIT_W-1:0];
  endfunction

  function automatic void apply_table_op(op_e op, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] now);
    logic              found;
    logic [TIME_W-1:0] quiet;
    found = 1'b0;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (!found && !slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_id[i]   = id;
            slot_seen[i] = now;
            found        = 1'b1;
          end
        end
      end
      OP_REMOVE, OP_REFRESH: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (!found && slot_used[i] && slot_id[i] == id) begin
            if (op == OP_REMOVE) slot_used[i] = 1'b0;
            else slot_seen[i] = now;
            found = 1'b1;
          end
        end
      end
      default: begin
        found = 1'b1;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (slot_used[i]) begin
            quiet = now - slot_seen[i];
            if (quiet > TIME_W'(dead_after)) begin
              queued_results.push_back(table_result_t'{KIND_EXPIRED, slot_id[i], 1'b0,
                                                       '0, 1'b0});
              slot_used[i] = 1'b0;
            end else if (probe_on) begin
              queued_results.push_back(table_result_t'{KIND_PROBE, slot_id[i], 1'b0,
                                                       '0, 1'b0});
            end
          end
        end
      end
    endcase
    queued_results.push_back(table_result_t'{KIND_DONE, '0, found, wait_until_check(now),
                                             1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t got;
    table_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_id[i]   = '0;
        slot_seen[i] = '0;
      end
      check_period = CHECK_PERIOD_RST;
      dead_after   = DEAD_AFTER_RST;
      probe_on     = 1'b1;
      queued_results.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = table_result_t'{kind_i, slot_client_i, ok_i, next_wait_ms_i, last_i};
        if (queued_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d client %h ok %0d wait %0d last %0d",
                     got.kind, got.client, got.ok, got.wait_ms, got.last);
          mismatches++;
        end else begin
          want = queued_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: expected kind %0d client %h ok %0d wait %0d last %0d, %s",
                       want.kind, want.client, want.ok, want.wait_ms, want.last,
                       $sformatf("got kind %0d client %h ok %0d wait %0d last %0d",
                                 got.kind, got.client, got.ok, got.wait_ms, got.last));
            mismatches++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:2]))
          REG_CHECK_PERIOD: check_period = pwdata_i[CFG_W-1:0];
          REG_DEAD_AFTER:   dead_after   = pwdata_i[CFG_W-1:0];
          REG_PROBE_ENABLE: probe_on     = pwdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        apply_table_op(op_e'(operation_i), client_id_i, now_ms_i);
      pending_o    <= queued_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/keepalive_client_timeout_table_core_test.sv =====
// testbench top for the keepalive client timeout table: clock, reset, request
// and configuration stimulus, verdict; uses kact_pkg and kact_table_checker
module keepalive_client_timeout_table_core_test;
  import kact_pkg::*;

  localparam int unsigned SLOTS = MAX_SLOTS_DEF;
  // cycles the block may still be busy once the last result is out
  localparam int unsigned DRAIN = SLOTS + 5;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  op_e                 operation;
  logic [ID_W-1:0]     client_id;
  logic [TIME_W-1:0]   now_ms;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          kind;
  logic [ID_W-1:0]     slot_client;
  logic                ok;
  logic [WAIT_W-1:0]   next_wait_ms;
  logic                last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int pending;
  int fail_count;

  // idle odds in percent, changed per phase
  int send_idle_pct;
  int recv_stall_pct;

  keepalive_client_timeout_table_core #(
    .MAX_SLOTS(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .client_id_i    (client_id),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .slot_client_o  (slot_client),
    .ok_o           (ok),
    .next_wait_ms_o (next_wait_ms),
    .last_o         (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  kact_table_checker #(
    .MAX_SLOTS(SLOTS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operation_i    (operation),
    .client_id_i    (client_id),
    .now_ms_i       (now_ms),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .slot_client_i  (slot_client),
    .ok_i           (ok),
    .next_wait_ms_i (next_wait_ms),
    .last_i         (last),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: ready drops at random, changed on the falling edge only
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // present one request, optionally after idle cycles, and hold it until taken
  task automatic send_request(input op_e op, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid  = 1'b1;
    operation = op;
    client_id = id;
    now_ms    = now;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // stop sending and wait for every predicted result to arrive
  task automatic hold_until_empty();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // write: setup phase, then access phase until pready
  task automatic apb_write(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers change only with the table idle and the scan finished
  task automatic set_config(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] dead,
                            input logic probe);
    hold_until_empty();
    repeat (DRAIN) @(posedge clk_i);
    apb_write(REG_CHECK_PERIOD, PDATA_W'(period));
    apb_write(REG_DEAD_AFTER, PDATA_W'(dead));
    apb_write(REG_PROBE_ENABLE, PDATA_W'(probe));
  endtask

  initial begin
    logic [ID_W-1:0]   id_pool [8];
    logic [TIME_W-1:0] wall_ms;
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] rnow;
    op_e               rop;
    int                roll;
    int                step_max;

    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    operation      = OP_ADD;
    client_id      = '0;
    now_ms         = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset settings
    // sweep on an empty table, then remove and refresh of an unknown client
    send_request(OP_SWEEP, 16'h0000, 48'd0);
    send_request(OP_REMOVE, 16'h1234, 48'd10);
    send_request(OP_REFRESH, 16'h1234, 48'd20);
    // extreme ids, then the same id added twice
    send_request(OP_ADD, 16'h0000, 48'd0);
    send_request(OP_ADD, 16'hFFFF, 48'd100);
    send_request(OP_ADD, 16'hFFFF, 48'd200);
    // refresh hits the lowest matching slot only
    send_request(OP_REFRESH, 16'hFFFF, 48'd3000);
    // all live, one slot at its check time so the wait clamps low
    send_request(OP_SWEEP, 16'hABCD, 48'd5000);
    send_request(OP_REMOVE, 16'hFFFF, 48'd5100);
    // fill the table, the last one stamped with the largest time
    for (int i = 0; i < 13; i++)
      send_request(OP_ADD, 16'($urandom), 48'd6000);
    send_request(OP_ADD, 16'h5A5A, 48'hFFFF_FFFF_FFFF);
    // add into a full table
    send_request(OP_ADD, 16'h0F0F, 48'd7000);
    // mix of expiries, probes and a slot stamped after the sweep time
    send_request(OP_SWEEP, 16'h0000, 48'd15000);

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = 16'($urandom);
    wall_ms = 48'd20000;

    // random phases, each with its own settings and idle pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(22'd1000, 22'd3600000, 1'b1);
        1: set_config(22'd0, 22'd0, 1'b0);
        2: set_config(22'd3600000, 22'd8000, 1'b1);
        default: set_config(22'd1, CFG_W'($urandom_range(0, 30000)),
                            1'($urandom_range(0, 1)));
      endcase
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      step_max = $urandom_range(500, 8000);
      // last phase runs the clock across the top of the time range
      if (phase == 3) wall_ms = 48'hFFFF_FFFF_C000;
      for (int n = 0; n < 21; n++) begin
        // one pause per phase with nothing left in flight
        if (n == 14) hold_until_empty();
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          // noise: any operation, any id, any time
          rop  = op_e'($urandom_range(0, 3));
          rid  = 16'($urandom);
          rnow = {16'($urandom), 32'($urandom)};
        end else begin
          // well formed: clock moves forward, ids from a small pool
          wall_ms = wall_ms + TIME_W'($urandom_range(0, step_max));
          roll = $urandom_range(0, 99);
          if (roll < 35) rop = OP_ADD;
          else if (roll < 60) rop = OP_REFRESH;
          else if (roll < 75) rop = OP_REMOVE;
          else rop = OP_SWEEP;
          rid  = id_pool[$urandom_range(0, 7)];
          rnow = wall_ms;
        end
        send_request(rop, rid, rnow);
      end
    end

    // let the last results out, then watch for strays
    hold_until_empty();
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
